/* src/cttt_pkg.sv */
// Shared types and constants for the condition / timeout trigger table.
// No dependencies; imported by condition_timeout_trigger_table.
package cttt_pkg;

   // operation codes
   localparam logic [1:0] OP_SET_TIME = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_CHECK    = 2'd2;

   // compare modes
   localparam logic [2:0] MODE_GE       = 3'd0;
   localparam logic [2:0] MODE_LE       = 3'd1;
   localparam logic [2:0] MODE_NEAR_1   = 3'd2;
   localparam logic [2:0] MODE_NEAR_10  = 3'd3;
   localparam logic [2:0] MODE_NEAR_100 = 3'd4;
   localparam logic [2:0] MODE_NEAR_1K  = 3'd5;

   // Q16.16 windows for the near modes, as 33-bit magnitudes
   localparam logic [32:0] Q_ONE      = 33'h0_0001_0000;
   localparam logic [32:0] Q_TEN      = 33'h0_000A_0000;
   localparam logic [32:0] Q_HUNDRED  = 33'h0_0064_0000;
   localparam logic [32:0] Q_THOUSAND = 33'h0_03E8_0000;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]         op;
      logic [63:0]        time_now;
      logic signed [31:0] current_value;
      logic signed [31:0] offset;
      logic [2:0]         compare_mode;
      logic [31:0]        rel_timeout;
      logic [2:0]         slot_select;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] slot_index;
      logic       fired;
      logic [3:0] pending;
   } rsp_type;

   // one slot as kept in the slot memory
   typedef struct packed {
      logic signed [31:0] target;
      logic [2:0]         mode;
      logic [63:0]        deadline;
   } slot_entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

/* src/cttt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the slot store of the trigger table.
module cttt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/condition_timeout_trigger_table.sv */
// Top level of the condition / timeout trigger table.
// Depends on cttt_pkg and cttt_ram (slot store).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  req     | in        | req_valid/req_ready  | cttt_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_ready  | cttt_pkg::rsp_type
//
// The accept cycle issues the slot memory read; the item is then evaluated
// and written back in the exec state. The memory read is registered, and no
// new item is taken until the current one has been evaluated.
// Reset clears busy bits, pending count, block clock and the handshakes;
// slot memory contents are not cleared, only busy slots can ever fire.
// A full result register stalls the evaluate cycle until rsp_ready; a
// waiting result does not block accepting the next item.
module condition_timeout_trigger_table #(
   parameter int SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cttt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cttt_pkg::rsp_type rsp_data
);

   import cttt_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SEL_W  = (SLOT_W > 3) ? SLOT_W : 3;   // room for both index forms
   localparam int PEND_W = (CNT_W > 4) ? CNT_W : 4;
   localparam int ENTRY_W = $bits(slot_entry_type);

   // control state
   state_type          state_ff, state_in;
   logic [SLOTS-1:0]   busy_ff, busy_in;
   logic [CNT_W-1:0]   pending_ff, pending_in;
   logic [63:0]        clock_now_ff, clock_now_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   req_type            item_ff;
   rsp_type            rsp_ff, rsp_in;

   // slot memory
   logic               ram_wr_en;
   logic [SLOT_W-1:0]  ram_wr_addr;
   slot_entry_type     ram_wr_entry;
   logic               ram_rd_en;
   logic [SLOT_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_bits;
   slot_entry_type     ram_rd_entry;

   // datapath
   logic               done;
   logic               free_found;
   logic [SLOT_W-1:0]  free_idx;
   logic [SEL_W-1:0]   req_sel_ext;
   logic [SEL_W-1:0]   sel_ext;
   logic [SLOT_W-1:0]  sel_idx;
   logic               sel_in_range;
   logic signed [32:0] target_sum;
   logic signed [31:0] target_sat;
   logic signed [33:0] diff;
   logic [32:0]        diff_mag;
   logic               cond_hit;
   logic               time_hit;
   logic               fire;
   logic               add_ok;
   logic [SEL_W-1:0]   free_ext;
   logic [PEND_W-1:0]  pend_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // read the selected slot as the item is taken
   assign req_sel_ext = SEL_W'(req_data.slot_select);
   assign ram_rd_en   = req_valid && req_ready;
   assign ram_rd_addr = req_sel_ext[SLOT_W-1:0];
   assign ram_rd_entry = slot_entry_type'(ram_rd_bits);

   cttt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ENTRY_W'(ram_wr_entry)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   // lowest-numbered free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // saturated target = base + offset
   always_comb begin
      target_sum = 33'(item_ff.current_value) + 33'(item_ff.offset);
      if (target_sum[32] != target_sum[31]) begin
         target_sat = target_sum[32] ? Q_MIN : Q_MAX;
      end else begin
         target_sat = target_sum[31:0];
      end
   end

   // check of the selected slot against its stored target and deadline
   assign sel_ext      = SEL_W'(item_ff.slot_select);
   assign sel_idx      = sel_ext[SLOT_W-1:0];
   assign sel_in_range = (32'(sel_ext) < 32'(SLOTS));

   // full-range difference fits 33 bits signed (kept in 34); its magnitude fits 32 (kept in 33)
   always_comb begin
      diff     = 34'(item_ff.current_value) - 34'(ram_rd_entry.target);
      diff_mag = diff[33] ? 33'(-diff) : 33'(diff);
      unique case (ram_rd_entry.mode)
         MODE_GE:       cond_hit = (item_ff.current_value >= ram_rd_entry.target);
         MODE_LE:       cond_hit = (item_ff.current_value <= ram_rd_entry.target);
         MODE_NEAR_1:   cond_hit = (diff_mag < Q_ONE);
         MODE_NEAR_10:  cond_hit = (diff_mag < Q_TEN);
         MODE_NEAR_100: cond_hit = (diff_mag < Q_HUNDRED);
         MODE_NEAR_1K:  cond_hit = (diff_mag < Q_THOUSAND);
         default:       cond_hit = 1'b0;   // never, and the unused code
      endcase
   end

   // zero deadline means no timeout
   assign time_hit = (ram_rd_entry.deadline != 64'd0) &&
                     (clock_now_ff >= ram_rd_entry.deadline);

   assign done   = !rsp_valid_ff || rsp_ready;
   assign add_ok = (item_ff.op == OP_ADD) && free_found;
   assign fire   = (item_ff.op == OP_CHECK) && sel_in_range && busy_ff[sel_idx] &&
                   (cond_hit || time_hit);

   assign free_ext = SEL_W'(free_idx);

   // write-back of an added slot
   assign ram_wr_en              = (state_ff == ST_EXEC) && done && add_ok;
   assign ram_wr_addr            = free_idx;
   assign ram_wr_entry.target    = target_sat;
   assign ram_wr_entry.mode      = item_ff.compare_mode;
   assign ram_wr_entry.deadline  = clock_now_ff + 64'(item_ff.rel_timeout);

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      pending_in   = pending_ff;
      clock_now_in = clock_now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pend_ext     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in = ST_IDLE;
               rsp_in   = '0;
               unique case (item_ff.op)
                  OP_SET_TIME: begin
                     clock_now_in = item_ff.time_now;
                  end
                  OP_ADD: begin
                     if (add_ok) begin
                        busy_in[free_idx] = 1'b1;
                        pending_in        = pending_ff + CNT_W'(1);
                        rsp_in.accepted   = 1'b1;
                        rsp_in.slot_index = free_ext[2:0];
                     end
                  end
                  OP_CHECK: begin
                     rsp_in.slot_index = item_ff.slot_select;
                     if (fire) begin
                        busy_in[sel_idx] = 1'b0;
                        pending_in       = pending_ff - CNT_W'(1);
                        rsp_in.fired     = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               pend_ext       = PEND_W'(pending_in);
               rsp_in.pending = pend_ext[3:0];
               rsp_valid_in   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         pending_ff   <= '0;
         clock_now_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         pending_ff   <= pending_in;
         clock_now_ff <= clock_now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // pending count tracks the busy bits
   a_pending_matches_busy: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == int'(pending_ff))
      else $error("pending count out of step with busy slots");

   // a taken item always puts the block in the evaluate state in the next cycle
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted item not evaluated");

   // a fired check frees exactly one slot
   a_fire_frees_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && done && fire) |=>
         (pending_ff == $past(pending_ff) - CNT_W'(1)))
      else $error("fired check did not free a slot");

   // an add never lands on a busy slot
   a_add_free_slot: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !busy_ff[ram_wr_addr])
      else $error("add wrote a busy slot");

endmodule
